// ===== rtl/core/pcx_pkg.sv =====
// shared types and constants for the pcx run-length palette expander
// no dependencies

package pcx_pkg;

   localparam int PCX_PALETTE_ENTRIES = 256;
   localparam int PCX_MAX_DIMENSION   = 4096;

   localparam int COLOR_W       = 8;
   localparam int RGB_W         = 3 * COLOR_W;
   localparam int PALETTE_ADDR_W = $clog2(PCX_PALETTE_ENTRIES);
   localparam int POS_W         = 12;
   localparam int RUN_W         = 6;
   localparam int CSR_INDEX_W   = 8;
   localparam int CSR_DATA_W    = 13;

   localparam logic [7:0]       RUN_MARK = 8'hBF;

   localparam logic             OP_PALETTE = 1'b0;
   localparam logic             OP_DATA    = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = CSR_INDEX_W'(1);

   typedef struct packed {
      logic accept;
      logic emit;
   } pcx_cmd_type;

   typedef struct packed {
      logic starts_run;
      logic out_free;
      logic last_pixel;
   } pcx_status_type;

endpackage

// ===== rtl/core/pcx_rle_palette_expander.sv =====
// top level of the pcx run-length decoder with palette expansion
// depends on pcx_pkg, pcx_ctrl and pcx_dpath
//
// Items with opcode 0 load one 24-bit palette entry; items with opcode 1 carry
// the compressed byte stream, where a byte above 0xBF gives a run count for
// the following byte. Each pixel comes out as RGB with its column and its
// vertically flipped row; last_of_run marks the final pixel of an item and
// image_done the final pixel of the image, after which the counters restart.
// Palette writes, run-count bytes and zero-length runs give no pixel and
// leave the controller idle. For a pixel item the palette read is issued as
// the item is accepted, then the controller emits one pixel per cycle
// through the output register while rsp_ready stays high and takes the next
// item once the run is finished. The palette needs no clearing after reset,
// but every entry must be written before a pixel uses it. Register writes
// (width, height; zero reads as 1) restart the pixel counters; the user
// must make them only while the block is idle, which the block does not enforce.

module pcx_rle_palette_expander
   import pcx_pkg::*;
#(
   parameter int MAX_DIMENSION = PCX_MAX_DIMENSION
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_opcode,
   input  logic [PALETTE_ADDR_W-1:0] req_palette_index,
   input  logic [COLOR_W-1:0]        req_palette_red,
   input  logic [COLOR_W-1:0]        req_palette_green,
   input  logic [COLOR_W-1:0]        req_palette_blue,
   input  logic [7:0]                req_data_byte,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [COLOR_W-1:0]        rsp_red,
   output logic [COLOR_W-1:0]        rsp_green,
   output logic [COLOR_W-1:0]        rsp_blue,
   output logic [POS_W-1:0]          rsp_column,
   output logic [POS_W-1:0]          rsp_flipped_row,
   output logic                      rsp_last_of_run,
   output logic                      rsp_image_done
);

   pcx_cmd_type    cmd;
   pcx_status_type status;

   assign csr_ready = 1'b1;

   pcx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pcx_dpath #(
      .MAX_DIMENSION (MAX_DIMENSION)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_opcode        (req_opcode),
      .req_palette_index (req_palette_index),
      .req_palette_red   (req_palette_red),
      .req_palette_green (req_palette_green),
      .req_palette_blue  (req_palette_blue),
      .req_data_byte     (req_data_byte),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue),
      .rsp_column        (rsp_column),
      .rsp_flipped_row   (rsp_flipped_row),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_image_done    (rsp_image_done)
   );

endmodule

// ===== rtl/core/pcx_ram.sv =====
// generic single write port memory with one registered read port
// no dependencies

module pcx_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/pcx_dpath.sv =====
// datapath: palette memory, run decode, pixel counters, output register
// depends on pcx_pkg and pcx_ram

module pcx_dpath
   import pcx_pkg::*;
#(
   parameter int MAX_DIMENSION = PCX_MAX_DIMENSION
) (
   input  logic                      clock,
   input  logic                      reset,
   input  pcx_cmd_type               cmd,
   output pcx_status_type            status,
   input  logic                      req_opcode,
   input  logic [PALETTE_ADDR_W-1:0] req_palette_index,
   input  logic [COLOR_W-1:0]        req_palette_red,
   input  logic [COLOR_W-1:0]        req_palette_green,
   input  logic [COLOR_W-1:0]        req_palette_blue,
   input  logic [7:0]                req_data_byte,
   input  logic                      csr_valid,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [COLOR_W-1:0]        rsp_red,
   output logic [COLOR_W-1:0]        rsp_green,
   output logic [COLOR_W-1:0]        rsp_blue,
   output logic [POS_W-1:0]          rsp_column,
   output logic [POS_W-1:0]          rsp_flipped_row,
   output logic                      rsp_last_of_run,
   output logic                      rsp_image_done
);

   localparam int CNT_W = $clog2(MAX_DIMENSION);
   localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
   localparam int EXT_W = (DIM_W > CSR_DATA_W) ? DIM_W : CSR_DATA_W;

   logic             awaiting_ff, awaiting_in;
   logic [RUN_W-1:0] pending_ff, pending_in;
   logic [RUN_W-1:0] remain_ff, remain_in;
   logic [CNT_W-1:0] col_ff, col_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [COLOR_W-1:0] rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic [POS_W-1:0]   rsp_column_ff, rsp_flipped_row_ff;
   logic               rsp_last_of_run_ff, rsp_image_done_ff;

   logic [RGB_W-1:0] rgb;
   logic             run_header;
   logic [DIM_W-1:0] col_ext, row_ext;
   logic             row_end, done;
   logic [EXT_W-1:0] cfg_ext, max_ext;
   logic [DIM_W-1:0] cfg_eff;

   pcx_ram #(
      .WIDTH (RGB_W),
      .DEPTH (PCX_PALETTE_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (cmd.accept && req_opcode == OP_PALETTE),
      .wr_addr (req_palette_index),
      .wr_data ({req_palette_red, req_palette_green, req_palette_blue}),
      .rd_en   (cmd.accept && req_opcode == OP_DATA),
      .rd_addr (req_data_byte),
      .rd_data (rgb)
   );

   assign run_header = req_data_byte > RUN_MARK;
   assign col_ext    = DIM_W'(col_ff);
   assign row_ext    = DIM_W'(row_ff);
   assign row_end    = (col_ext + DIM_W'(1)) >= width_ff;
   assign done       = row_end && ((row_ext + DIM_W'(1)) >= height_ff);

   // zero reads as one, large values saturate
   assign cfg_ext = EXT_W'(csr_wdata);
   assign max_ext = EXT_W'(MAX_DIMENSION);
   always_comb begin
      if (cfg_ext == '0) begin
         cfg_eff = DIM_W'(1);
      end else if (cfg_ext > max_ext) begin
         cfg_eff = DIM_W'(MAX_DIMENSION);
      end else begin
         cfg_eff = DIM_W'(cfg_ext);
      end
   end

   assign status.starts_run = req_opcode == OP_DATA &&
                              (awaiting_ff ? pending_ff != '0 : !run_header);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;
   assign status.last_pixel = done || remain_ff == RUN_W'(1);

   always_comb begin
      awaiting_in  = awaiting_ff;
      pending_in   = pending_ff;
      remain_in    = remain_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (cmd.accept && req_opcode == OP_DATA) begin
         if (awaiting_ff) begin
            awaiting_in = 1'b0;
            pending_in  = '0;
            remain_in   = pending_ff;
         end else if (run_header) begin
            awaiting_in = 1'b1;
            pending_in  = req_data_byte[RUN_W-1:0];
         end else begin
            remain_in = RUN_W'(1);
         end
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         remain_in    = remain_ff - RUN_W'(1);
         if (done) begin
            col_in    = '0;
            row_in    = '0;
            remain_in = '0;
         end else if (row_end) begin
            col_in = '0;
            row_in = row_ff + CNT_W'(1);
         end else begin
            col_in = col_ff + CNT_W'(1);
         end
      end

      if (csr_valid) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH: begin
               width_in = cfg_eff;
               col_in   = '0;
               row_in   = '0;
            end
            CSR_IMAGE_HEIGHT: begin
               height_in = cfg_eff;
               col_in    = '0;
               row_in    = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff  <= 1'b0;
         pending_ff   <= '0;
         remain_ff    <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         width_ff     <= DIM_W'(1);
         height_ff    <= DIM_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         awaiting_ff  <= awaiting_in;
         pending_ff   <= pending_in;
         remain_ff    <= remain_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_red_ff         <= rgb[RGB_W-1 -: COLOR_W];
         rsp_green_ff       <= rgb[COLOR_W +: COLOR_W];
         rsp_blue_ff        <= rgb[COLOR_W-1:0];
         rsp_column_ff      <= POS_W'(col_ff);
         rsp_flipped_row_ff <= POS_W'(height_ff - DIM_W'(1) - row_ext);
         rsp_last_of_run_ff <= status.last_pixel;
         rsp_image_done_ff  <= done;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_red         = rsp_red_ff;
   assign rsp_green       = rsp_green_ff;
   assign rsp_blue        = rsp_blue_ff;
   assign rsp_column      = rsp_column_ff;
   assign rsp_flipped_row = rsp_flipped_row_ff;
   assign rsp_last_of_run = rsp_last_of_run_ff;
   assign rsp_image_done  = rsp_image_done_ff;

`ifndef SYNTH
   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("pixel loaded over an undelivered item");

   a_emit_has_count: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> remain_ff != '0)
      else $error("pixel emitted with no run count left");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      col_ext < width_ff && row_ext < height_ff)
      else $error("pixel counters beyond image size");

   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_image_done_ff |-> rsp_last_of_run_ff)
      else $error("image end without end of run");
`endif

endmodule

// ===== rtl/core/pcx_ctrl.sv =====
// controller: idle / emit sequencing of input acceptance and pixel output
// depends on pcx_pkg

module pcx_ctrl
   import pcx_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  pcx_status_type status,
   output pcx_cmd_type    cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic state_ff, state_in;

   assign req_ready  = state_ff == ST_IDLE;
   assign cmd.accept = req_valid && req_ready;
   assign cmd.emit   = state_ff == ST_EMIT && status.out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.accept && status.starts_run) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (cmd.emit && status.last_pixel) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
